// ===== design/dual_supply_monitor_hysteresis_assert.svh =====
// Assertion macros for the dual supply monitor checker.
// Each macro expects clk and rst_n in scope.
`ifndef DUAL_SUPPLY_MONITOR_HYSTERESIS_ASSERT_SVH
`define DUAL_SUPPLY_MONITOR_HYSTERESIS_ASSERT_SVH

// same-cycle implication
`define DSMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dsmh_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmh_pkg
// Shared types and constants of the dual supply monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package dsmh_pkg;

  localparam int SAMPLES_PER_BURST  = 32;
  localparam int BURSTS_PER_READING = 8;
  localparam int IDLE_TICKS         = 100;

  localparam int AVG_W   = 10;
  localparam int SUM_W   = 15;
  localparam int TMR_W   = 16;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [AVG_W-1:0] AVG_MAX = 10'd1023;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_MAIN_HIGH_SET   = 4'd0;
  localparam cfg_idx_t REG_MAIN_HIGH_CLEAR = 4'd1;
  localparam cfg_idx_t REG_MAIN_LOW_SET    = 4'd2;
  localparam cfg_idx_t REG_MAIN_LOW_CLEAR  = 4'd3;
  localparam cfg_idx_t REG_BATT_HIGH_SET   = 4'd4;
  localparam cfg_idx_t REG_BATT_HIGH_CLEAR = 4'd5;
  localparam cfg_idx_t REG_BATT_LOW_SET    = 4'd6;
  localparam cfg_idx_t REG_BATT_LOW_CLEAR  = 4'd7;

  localparam logic [AVG_W-1:0] RST_HIGH_SET   = 10'd1000;
  localparam logic [AVG_W-1:0] RST_HIGH_CLEAR = 10'd960;
  localparam logic [AVG_W-1:0] RST_LOW_SET    = 10'd100;
  localparam logic [AVG_W-1:0] RST_LOW_CLEAR  = 10'd140;

  // event kind codes on the result word
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_HIGH   = 2'd1;
  localparam logic [1:0] KIND_LOW    = 2'd2;

  localparam logic CHAN_MAIN = 1'b0;
  localparam logic CHAN_BATT = 1'b1;

  typedef enum logic [2:0] {
    LVL_NORMAL = 3'b001,
    LVL_HIGH   = 3'b010,
    LVL_LOW    = 3'b100
  } lvl_t;

  typedef struct packed {
    logic [AVG_W-1:0] high_set;
    logic [AVG_W-1:0] high_clear;
    logic [AVG_W-1:0] low_set;
    logic [AVG_W-1:0] low_clear;
  } thr_t;

  typedef struct packed {
    lvl_t       level_nxt;
    logic       changed;
    logic [1:0] kind;
  } hyst_res_t;

  typedef struct packed {
    logic             action;
    logic [SUM_W-1:0] burst_sum;
  } in_word_t;

  typedef struct packed {
    logic             start_request;
    logic             start_channel;
    logic             reading_valid;
    logic [AVG_W-1:0] reading_value;
    logic             event_valid;
    logic             event_channel;
    logic [1:0]       event_kind;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/dsmh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dsmh_cfg_regs
// Threshold register file for both supply channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmh_cfg_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  dsmh_pkg::cfg_idx_t           wr_index,
  input  wire [dsmh_pkg::AVG_W-1:0]    wr_data,
  output dsmh_pkg::thr_t               thr_main,
  output dsmh_pkg::thr_t               thr_batt
);
  import dsmh_pkg::*;

  thr_t main_r, main_nxt;
  thr_t batt_r, batt_nxt;

  always_comb begin
    main_nxt = main_r;
    batt_nxt = batt_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MAIN_HIGH_SET:   main_nxt.high_set   = wr_data;
        REG_MAIN_HIGH_CLEAR: main_nxt.high_clear = wr_data;
        REG_MAIN_LOW_SET:    main_nxt.low_set    = wr_data;
        REG_MAIN_LOW_CLEAR:  main_nxt.low_clear  = wr_data;
        REG_BATT_HIGH_SET:   batt_nxt.high_set   = wr_data;
        REG_BATT_HIGH_CLEAR: batt_nxt.high_clear = wr_data;
        REG_BATT_LOW_SET:    batt_nxt.low_set    = wr_data;
        REG_BATT_LOW_CLEAR:  batt_nxt.low_clear  = wr_data;
        default: ;  // index beyond the list: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r <= '{RST_HIGH_SET, RST_HIGH_CLEAR, RST_LOW_SET, RST_LOW_CLEAR};
      batt_r <= '{RST_HIGH_SET, RST_HIGH_CLEAR, RST_LOW_SET, RST_LOW_CLEAR};
    end else begin
      main_r <= main_nxt;
      batt_r <= batt_nxt;
    end
  end

  assign thr_main = main_r;
  assign thr_batt = batt_r;

endmodule

`default_nettype wire

// ===== design/dsmh_hyst.sv =====
// ----------------------------------------------------------------------------
// dsmh_hyst
// Normal/high/low hysteresis step, shared by both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmh_hyst (
  input  dsmh_pkg::lvl_t               level,
  input  wire [dsmh_pkg::AVG_W-1:0]    avg,
  input  dsmh_pkg::thr_t               thr,
  output dsmh_pkg::hyst_res_t          res
);
  import dsmh_pkg::*;

  always_comb begin
    res.level_nxt = level;
    res.changed   = 1'b0;
    res.kind      = KIND_NORMAL;
    unique case (level)
      LVL_HIGH: begin
        if (avg <= thr.high_clear) begin
          res.level_nxt = LVL_NORMAL;
          res.changed   = 1'b1;
          res.kind      = KIND_NORMAL;
        end
      end
      LVL_LOW: begin
        if (avg >= thr.low_clear) begin
          res.level_nxt = LVL_NORMAL;
          res.changed   = 1'b1;
          res.kind      = KIND_NORMAL;
        end
      end
      default: begin
        res.level_nxt = LVL_NORMAL;
        // high check wins when both thresholds match
        if (avg >= thr.high_set) begin
          res.level_nxt = LVL_HIGH;
          res.changed   = 1'b1;
          res.kind      = KIND_HIGH;
        end else if (avg <= thr.low_set) begin
          res.level_nxt = LVL_LOW;
          res.changed   = 1'b1;
          res.kind      = KIND_LOW;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dsmh_core.sv =====
// ----------------------------------------------------------------------------
// dsmh_core
// Burst scheduler, burst averaging and per-channel level state.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmh_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  dsmh_pkg::in_word_t  word,
  input  dsmh_pkg::thr_t      thr_main,
  input  dsmh_pkg::thr_t      thr_batt,
  output dsmh_pkg::out_word_t res
);
  import dsmh_pkg::*;

  logic             waiting_r, waiting_nxt;
  logic [TMR_W-1:0] timer_r,   timer_nxt;
  logic             chan_r,    chan_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [TOT_W-1:0] total_r,   total_nxt;
  lvl_t             main_lvl_r, main_lvl_nxt;
  lvl_t             batt_lvl_r, batt_lvl_nxt;

  logic [SUM_W-1:0] quot;
  logic [AVG_W-1:0] burst_avg;
  logic [TMR_W-1:0] timer_dec;
  logic [CNT_W-1:0] count_inc;
  logic [TOT_W-1:0] total_add;
  logic [TOT_W-1:0] total_div;
  logic [AVG_W-1:0] avg;
  lvl_t             cur_lvl;
  thr_t             cur_thr;
  hyst_res_t        hres;

  // both divisors are powers of two: plain shifts
  assign quot      = SUM_W'(word.burst_sum / SAMPLES_PER_BURST);
  assign burst_avg = (quot > SUM_W'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];
  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;
  assign count_inc = count_r + 1'b1;
  assign total_add = total_r + TOT_W'(burst_avg);
  assign total_div = TOT_W'(total_add / BURSTS_PER_READING);
  assign avg       = (total_div > TOT_W'(AVG_MAX)) ? AVG_MAX : total_div[AVG_W-1:0];

  assign cur_lvl = (chan_r == CHAN_MAIN) ? main_lvl_r : batt_lvl_r;
  assign cur_thr = (chan_r == CHAN_MAIN) ? thr_main : thr_batt;

  dsmh_hyst u_hyst (
    .level (cur_lvl),
    .avg   (avg),
    .thr   (cur_thr),
    .res   (hres)
  );

  always_comb begin
    waiting_nxt  = waiting_r;
    timer_nxt    = timer_r;
    chan_nxt     = chan_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    main_lvl_nxt = main_lvl_r;
    batt_lvl_nxt = batt_lvl_r;
    res          = '0;

    if (!word.action) begin
      // tick
      timer_nxt = timer_dec;
      if (!waiting_r && timer_dec == '0) begin
        waiting_nxt       = 1'b1;
        res.start_request = 1'b1;
        res.start_channel = chan_r;
      end
    end else if (waiting_r) begin
      // burst done; a burst while idle is dropped
      waiting_nxt = 1'b0;
      count_nxt   = count_inc;
      total_nxt   = total_add;
      timer_nxt   = TMR_W'(1);
      if (count_inc >= CNT_W'(BURSTS_PER_READING)) begin
        res.reading_valid = 1'b1;
        res.reading_value = avg;
        if (chan_r == CHAN_MAIN) begin
          main_lvl_nxt = hres.level_nxt;
        end else begin
          batt_lvl_nxt = hres.level_nxt;
          timer_nxt    = TMR_W'(IDLE_TICKS);
        end
        if (hres.changed) begin
          res.event_valid   = 1'b1;
          res.event_channel = chan_r;
          res.event_kind    = hres.kind;
        end
        chan_nxt  = ~chan_r;
        count_nxt = '0;
        total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r  <= 1'b0;
      timer_r    <= TMR_W'(IDLE_TICKS);
      chan_r     <= CHAN_MAIN;
      count_r    <= '0;
      total_r    <= '0;
      main_lvl_r <= LVL_NORMAL;
      batt_lvl_r <= LVL_NORMAL;
    end else if (step) begin
      waiting_r  <= waiting_nxt;
      timer_r    <= timer_nxt;
      chan_r     <= chan_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      main_lvl_r <= main_lvl_nxt;
      batt_lvl_r <= batt_lvl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dual_supply_monitor_hysteresis.sv =====
// ----------------------------------------------------------------------------
// dual_supply_monitor_hysteresis
// Burst scheduler and hysteresis level monitor for main supply and battery.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per tick (action 0) or finished A/D burst (action 1,
//           with burst_sum). valid/ready handshake.
//   out_* : exactly one result word per input word, in order; it may carry a
//           start request, or a completed channel average and optional level event.
//   cfg_* : threshold writes, index 0..7; other indexes are dropped.
//           cfg_ready is always high.
//   The result word passes the input register, then the result register,
//   and is registered. Throughput is one word per cycle while out_ready
//   stays high; the state update sits in the single logic stage between
//   the two registers.
//   While out_ready is low the result register holds its word; the input
//   register still takes one more word, after which in_ready drops.
//   Synchronous reset restores the default thresholds, normal levels on
//   both channels, main channel selected and the long idle wait loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_supply_monitor_hysteresis (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  dsmh_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output dsmh_pkg::out_word_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  dsmh_pkg::cfg_idx_t           cfg_index,
  input  wire [dsmh_pkg::AVG_W-1:0]    cfg_data
);
  import dsmh_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t res;
  thr_t      thr_main;
  thr_t      thr_batt;
  logic      advance;
  logic      in_fire;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  dsmh_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .thr_main (thr_main),
    .thr_batt (thr_batt)
  );

  dsmh_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_valid_r && advance),
    .word     (s1_word_r),
    .thr_main (thr_main),
    .thr_batt (thr_batt),
    .res      (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// ===== design/dsmh_checker.sv =====
// ----------------------------------------------------------------------------
// dsmh_checker
// Port-level checks on the dual supply monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_supply_monitor_hysteresis_assert.svh"

module dsmh_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  dsmh_pkg::in_word_t           in_data,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  dsmh_pkg::out_word_t          out_data,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  dsmh_pkg::cfg_idx_t           cfg_index,
  input  wire [dsmh_pkg::AVG_W-1:0]    cfg_data
);
  import dsmh_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_ready, in_data, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // an event only comes with a completed average
  `DSMH_ASSERT_NOW(a_event_has_reading, out_valid && out_data.event_valid,
    out_data.reading_valid, "level event without a reading")

  // a start request and a reading never share a word
  `DSMH_ASSERT_NOW(a_start_xor_reading, out_valid && out_data.start_request,
    !out_data.reading_valid && !out_data.event_valid, "start request mixed with reading")

  // event fields are zero when no event is flagged
  `DSMH_ASSERT_NOW(a_idle_fields_zero, out_valid && !out_data.event_valid,
    out_data.event_channel == 1'b0 && out_data.event_kind == KIND_NORMAL,
    "event fields set without event")

  // stalled result word holds
  `DSMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data), "result word changed while stalled")

endmodule

bind dual_supply_monitor_hysteresis dsmh_checker u_dsmh_checker (.*);

`default_nettype wire
